// ----- hdl/white_balance_tone_lut_pixel_top_defines.svh -----
// ----------------------------------------------------------------------------
// White balance tone LUT pixel - assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WHITE_BALANCE_TONE_LUT_PIXEL_TOP_DEFINES_SVH
`define WHITE_BALANCE_TONE_LUT_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication.
`define WBTL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WBTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/wbtl_pkg.sv -----
// ----------------------------------------------------------------------------
// wbtl_pkg
// Widths, codes and helper functions of the white balance tone LUT pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wbtl_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TABLE_DEPTH = 65536;
   localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int PORT_W      = 16;   // sample ports
   localparam int ADDR_W      = 16;   // table address port
   localparam int TVAL_W      = 24;   // tone gain, Q8.16
   localparam int GAIN_W      = 20;   // channel gain, Q4.16
   localparam int SAT_W       = 16;   // saturation, Q2.14
   localparam int NARROW_BITS = 8;
   localparam int NARROW_FULL = 1 << NARROW_BITS;

   localparam int GAIN_SHIFT  = 16;
   localparam int SAT_SHIFT   = 14;
   localparam int PROD_SHIFT  = 30;

   localparam int PROD_W      = SAMPLE_BITS + GAIN_W - GAIN_SHIFT;
   localparam int IDX_W       = SAMPLE_BITS;
   localparam int CAP_W       = SAMPLE_BITS + 1;
   localparam int DIFF_W      = SAMPLE_BITS + 2;
   localparam int BLEND_W     = SAT_W + DIFF_W + 1;
   localparam int MAG_W       = BLEND_W - 1;
   localparam int VALUE_W     = MAG_W + TVAL_W;
   localparam int RES_W       = VALUE_W - PROD_SHIFT;

   localparam int CSR_W       = 20;
   localparam int CSR_INDEX_W = 3;

   localparam logic [SAMPLE_BITS-1:0] NARROW_MASK = SAMPLE_BITS'(NARROW_FULL - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RED_GAIN     = 3'd0,
      CSR_GREEN_GAIN   = 3'd1,
      CSR_BLUE_GAIN    = 3'd2,
      CSR_SATURATION   = 3'd3,
      CSR_WIDE_SAMPLES = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL       = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } op_type;

   // Per-stage load enables of the pixel pipeline.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   // Full scale of the current sample mode.
   function automatic logic [CAP_W-1:0] full_scale(input logic wide);
      return wide ? (CAP_W'(1) << SAMPLE_BITS) : CAP_W'(NARROW_FULL);
   endfunction

   // Full scale minus one.
   function automatic logic [IDX_W-1:0] full_max(input logic wide);
      return wide ? {IDX_W{1'b1}} : IDX_W'(NARROW_FULL - 1);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/wbtl_ram.sv -----
// ----------------------------------------------------------------------------
// wbtl_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wbtl_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/wbtl_lane.sv -----
// ----------------------------------------------------------------------------
// wbtl_lane
// One color channel: gain multiply, saturation blend, tone gain and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module wbtl_lane (
   input  logic                         clock,
   input  wbtl_pkg::stage_en_type       en,
   input  logic                         wide,
   input  logic [wbtl_pkg::GAIN_W-1:0]  gain,
   input  logic [wbtl_pkg::SAT_W-1:0]   sat,
   input  logic [wbtl_pkg::PORT_W-1:0]  smp,
   input  logic [wbtl_pkg::IDX_W-1:0]   idx,        // stage 2
   input  logic [wbtl_pkg::TVAL_W-1:0]  tone_gain,  // stage 3
   output logic [wbtl_pkg::PROD_W-1:0]  prod,       // stage 1
   output logic [wbtl_pkg::PORT_W-1:0]  result      // stage 5
);

   import wbtl_pkg::*;

   logic [SAMPLE_BITS-1:0]        smp_masked;
   logic [SAMPLE_BITS+GAIN_W-1:0] gained;
   logic [PROD_W-1:0]             prod1_in, prod1_ff, prod2_ff;

   logic [CAP_W-1:0]              full, capped;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [BLEND_W-1:0]     scaled, idx_shifted, blend_in, blend_ff;

   logic                          blend_pos;
   logic [MAG_W-1:0]              mag;
   logic [VALUE_W-1:0]            value_in, value_ff;

   logic [IDX_W-1:0]              lim;
   logic [RES_W-1:0]              res;
   logic [PORT_W-1:0]             result_in, result_ff;

   // Stage 1: drop sample bits above the mode width, apply channel gain.
   always_comb begin
      smp_masked = smp[SAMPLE_BITS-1:0];
      if (!wide) begin
         smp_masked = smp_masked & NARROW_MASK;
      end
      gained   = (SAMPLE_BITS+GAIN_W)'(smp_masked) * (SAMPLE_BITS+GAIN_W)'(gain);
      prod1_in = gained[SAMPLE_BITS+GAIN_W-1:GAIN_SHIFT];
   end

   // Stage 3: blend toward the index, index*one - sat*(index - capped).
   always_comb begin
      full = full_scale(wide);
      if (prod2_ff > PROD_W'(full)) begin
         capped = full;
      end else begin
         capped = CAP_W'(prod2_ff);
      end
      diff        = $signed({2'b00, idx}) - $signed({1'b0, capped});
      scaled      = $signed({1'b0, sat}) * diff;
      idx_shifted = $signed({{(BLEND_W-IDX_W-SAT_SHIFT){1'b0}}, idx, {SAT_SHIFT{1'b0}}});
      blend_in    = idx_shifted - scaled;
   end

   // Stage 4: apply tone gain; a non-positive blend yields zero.
   always_comb begin
      blend_pos = !blend_ff[BLEND_W-1] && (blend_ff != '0);
      mag       = blend_ff[MAG_W-1:0];
      value_in  = blend_pos ? (VALUE_W'(mag) * VALUE_W'(tone_gain)) : '0;
   end

   // Stage 5: drop fraction, clamp to full scale minus one.
   always_comb begin
      lim = full_max(wide);
      res = value_ff[VALUE_W-1:PROD_SHIFT];
      if (res > RES_W'(lim)) begin
         result_in = PORT_W'(lim);
      end else begin
         result_in = PORT_W'(res);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod1_ff <= prod1_in;
      end
      if (en.s2) begin
         prod2_ff <= prod1_ff;
      end
      if (en.s3) begin
         blend_ff <= blend_in;
      end
      if (en.s4) begin
         value_ff <= value_in;
      end
      if (en.s5) begin
         result_ff <= result_in;
      end
   end

   assign prod   = prod1_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ----- hdl/wbtl_merge.sv -----
// ----------------------------------------------------------------------------
// wbtl_merge
// Combines the lane products into the table index and looks up the tone gain.
// ----------------------------------------------------------------------------
`default_nettype none

module wbtl_merge (
   input  logic                         clock,
   input  wbtl_pkg::stage_en_type       en,
   input  logic                         wide,
   input  logic [wbtl_pkg::PROD_W-1:0]  prod_blue,
   input  logic [wbtl_pkg::PROD_W-1:0]  prod_green,
   input  logic [wbtl_pkg::PROD_W-1:0]  prod_red,
   input  logic                         wr_fire,
   input  logic [wbtl_pkg::ADDR_W-1:0]  table_address,
   input  logic [wbtl_pkg::TVAL_W-1:0]  table_value,
   output logic [wbtl_pkg::IDX_W-1:0]   idx,        // stage 2
   output logic [wbtl_pkg::TVAL_W-1:0]  tone_gain   // stage 3
);

   import wbtl_pkg::*;

   logic [ADDR_W-1:0] wr_addr1_ff;
   logic [TVAL_W-1:0] wr_data1_ff;
   logic [31:0]       wr_addr_ext, idx_ext;
   logic              wr_ok;

   logic [PROD_W-1:0] prod_max;
   logic [IDX_W-1:0]  lim, idx_in, idx2_ff;
   logic              inrange_in, inrange2_ff;
   logic [TVAL_W-1:0] ram_rdata, gain3_in, gain3_ff;

   always_comb begin
      prod_max = prod_blue;
      if (prod_green > prod_max) begin
         prod_max = prod_green;
      end
      if (prod_red > prod_max) begin
         prod_max = prod_red;
      end
      lim = full_max(wide);
      if (prod_max > PROD_W'(lim)) begin
         idx_in = lim;
      end else begin
         idx_in = IDX_W'(prod_max);
      end
      idx_ext     = 32'(idx_in);
      inrange_in  = idx_ext < 32'(TABLE_DEPTH);
      wr_addr_ext = 32'(wr_addr1_ff);
      // drop writes beyond the table
      wr_ok       = wr_fire && (wr_addr_ext < 32'(TABLE_DEPTH));
      gain3_in    = inrange2_ff ? ram_rdata : '0;
   end

   wbtl_ram #(
      .WIDTH (TVAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_tone_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr_ext[TABLE_AW-1:0]),
      .wr_data (wr_data1_ff),
      .rd_en   (en.s2),
      .rd_addr (idx_ext[TABLE_AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (en.s1) begin
         wr_addr1_ff <= table_address;
         wr_data1_ff <= table_value;
      end
      if (en.s2) begin
         idx2_ff     <= idx_in;
         inrange2_ff <= inrange_in;
      end
      if (en.s3) begin
         gain3_ff <= gain3_in;
      end
   end

   assign idx       = idx2_ff;
   assign tone_gain = gain3_ff;

endmodule

`default_nettype wire

// ----- hdl/white_balance_tone_lut_pixel_top.sv -----
// A pixel request passes stages 1 to 5 in order; its response comes from the stage 5 registers.
// Throughput: one request per cycle, pixel or table write, unless rsp_ready stalls the output;
//   the five-stage lane pipeline and the tone table's separate write and read ports allow it.
// A table write takes one pipeline slot and gives no response.
// Reset clears the stage valid bits and restores the gain, saturation and mode registers;
//   the tone table is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// white_balance_tone_lut_pixel_top
// Per-pixel white balance with tone-gain table, three channel lanes and a merge.
// ----------------------------------------------------------------------------
`default_nettype none

module white_balance_tone_lut_pixel_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [wbtl_pkg::PORT_W-1:0]       req_blue_in,
   input  logic [wbtl_pkg::PORT_W-1:0]       req_green_in,
   input  logic [wbtl_pkg::PORT_W-1:0]       req_red_in,
   input  logic [wbtl_pkg::ADDR_W-1:0]       req_table_address,
   input  logic [wbtl_pkg::TVAL_W-1:0]       req_table_value,
   input  logic                              req_frame_last,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wbtl_pkg::PORT_W-1:0]       rsp_blue_out,
   output logic [wbtl_pkg::PORT_W-1:0]       rsp_green_out,
   output logic [wbtl_pkg::PORT_W-1:0]       rsp_red_out,
   output logic                              rsp_frame_end,

   input  logic                              csr_wr_en,
   input  logic [wbtl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wbtl_pkg::CSR_W-1:0]        csr_wdata
);

   import wbtl_pkg::*;

   logic [GAIN_W-1:0] red_gain_ff, green_gain_ff, blue_gain_ff;
   logic [SAT_W-1:0]  sat_ff;
   logic              wide_ff;

   stage_en_type      en;
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic              v2_in;
   op_type            op1_ff;
   logic              last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic              wr_fire;

   logic [PROD_W-1:0] prod_blue, prod_green, prod_red;
   logic [IDX_W-1:0]  idx;
   logic [TVAL_W-1:0] tone_gain;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         red_gain_ff   <= GAIN_W'(65536);
         green_gain_ff <= GAIN_W'(65536);
         blue_gain_ff  <= GAIN_W'(65536);
         sat_ff        <= SAT_W'(16384);
         wide_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RED_GAIN:     red_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_GREEN_GAIN:   green_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_BLUE_GAIN:    blue_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_SATURATION:   sat_ff        <= csr_wdata[SAT_W-1:0];
            CSR_WIDE_SAMPLES: wide_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      en.s5   = !v5_ff || rsp_ready;
      en.s4   = !v4_ff || en.s5;
      en.s3   = !v3_ff || en.s4;
      en.s2   = !v2_ff || en.s3;
      en.s1   = !v1_ff || en.s2;
      wr_fire = v1_ff && (op1_ff == OP_TABLE_WRITE) && en.s2;
      // table writes end at stage 1
      v2_in   = v1_ff && (op1_ff == OP_PIXEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v2_in;
         if (en.s3) v3_ff <= v2_ff;
         if (en.s4) v4_ff <= v3_ff;
         if (en.s5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         op1_ff   <= op_type'(req_op);
         last1_ff <= req_frame_last;
      end
      if (en.s2) last2_ff <= last1_ff;
      if (en.s3) last3_ff <= last2_ff;
      if (en.s4) last4_ff <= last3_ff;
      if (en.s5) last5_ff <= last4_ff;
   end

   wbtl_lane u_lane_blue (
      .clock     (clock),
      .en        (en),
      .wide      (wide_ff),
      .gain      (blue_gain_ff),
      .sat       (sat_ff),
      .smp       (req_blue_in),
      .idx       (idx),
      .tone_gain (tone_gain),
      .prod      (prod_blue),
      .result    (rsp_blue_out)
   );

   wbtl_lane u_lane_green (
      .clock     (clock),
      .en        (en),
      .wide      (wide_ff),
      .gain      (green_gain_ff),
      .sat       (sat_ff),
      .smp       (req_green_in),
      .idx       (idx),
      .tone_gain (tone_gain),
      .prod      (prod_green),
      .result    (rsp_green_out)
   );

   wbtl_lane u_lane_red (
      .clock     (clock),
      .en        (en),
      .wide      (wide_ff),
      .gain      (red_gain_ff),
      .sat       (sat_ff),
      .smp       (req_red_in),
      .idx       (idx),
      .tone_gain (tone_gain),
      .prod      (prod_red),
      .result    (rsp_red_out)
   );

   wbtl_merge u_merge (
      .clock         (clock),
      .en            (en),
      .wide          (wide_ff),
      .prod_blue     (prod_blue),
      .prod_green    (prod_green),
      .prod_red      (prod_red),
      .wr_fire       (wr_fire),
      .table_address (req_table_address),
      .table_value   (req_table_value),
      .idx           (idx),
      .tone_gain     (tone_gain)
   );

   assign req_ready     = en.s1;
   assign rsp_valid     = v5_ff;
   assign rsp_frame_end = last5_ff;

endmodule

`default_nettype wire

// ----- hdl/wbtl_checker.sv -----
// ----------------------------------------------------------------------------
// wbtl_checker
// Port-level checks of the white balance tone LUT block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "white_balance_tone_lut_pixel_top_defines.svh"

module wbtl_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [wbtl_pkg::PORT_W-1:0]       rsp_blue_out,
   input  logic [wbtl_pkg::PORT_W-1:0]       rsp_green_out,
   input  logic [wbtl_pkg::PORT_W-1:0]       rsp_red_out,
   input  logic                              rsp_frame_end
);

   // A stalled response holds.
   `WBTL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_blue_out) && $stable(rsp_green_out) && $stable(rsp_red_out) && $stable(rsp_frame_end), "stalled response changed")

   // Input side never blocks while the output side can move.
   `WBTL_ASSERT_IMPL(a_ready_when_drained, !rsp_valid || rsp_ready, req_ready, "request blocked with output free")

   // Pipeline comes out of reset empty and stays empty for the next cycle.
   `WBTL_ASSERT_IMPL(a_empty_after_reset, $past(reset), !rsp_valid, "response right after reset")
   `WBTL_ASSERT_NEXT(a_no_early_rsp, $past(reset), !rsp_valid, "response too soon after reset")

endmodule

bind white_balance_tone_lut_pixel_top wbtl_checker u_wbtl_checker (.*);

`default_nettype wire

// ----- bench/white_balance_tone_lut_pixel_top_test.sv -----
// ----------------------------------------------------------------------------
// white_balance_tone_lut_pixel_top_test
// Self-checking bench for the white balance pixel pipeline. It drives pixel and
// tone table requests through the valid/ready port and sweeps the gain, saturation
// and sample-mode settings. Each pixel response is checked against a bit-exact
// software copy of the gain, index, blend and clamp arithmetic.
// ----------------------------------------------------------------------------
module white_balance_tone_lut_pixel_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wbtl_pkg::*;

   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int RUN_LIMIT_NS = 1_000_000;

   typedef struct packed {
      logic [PORT_W-1:0] blue;
      logic [PORT_W-1:0] green;
      logic [PORT_W-1:0] red;
      logic              frame_end;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   op_type                req_op = OP_PIXEL;
   logic [PORT_W-1:0]     req_blue_in = '0;
   logic [PORT_W-1:0]     req_green_in = '0;
   logic [PORT_W-1:0]     req_red_in = '0;
   logic [ADDR_W-1:0]     req_table_address = '0;
   logic [TVAL_W-1:0]     req_table_value = '0;
   logic                  req_frame_last = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PORT_W-1:0]     rsp_blue_out;
   logic [PORT_W-1:0]     rsp_green_out;
   logic [PORT_W-1:0]     rsp_red_out;
   logic                  rsp_frame_end;

   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_RED_GAIN;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Shadow of the block's settings and tone table
   logic [GAIN_W-1:0]     cfg_red_gain = 20'd65536;
   logic [GAIN_W-1:0]     cfg_green_gain = 20'd65536;
   logic [GAIN_W-1:0]     cfg_blue_gain = 20'd65536;
   logic [SAT_W-1:0]      cfg_saturation = 16'd16384;
   logic                  cfg_wide = 1'b0;
   logic [TVAL_W-1:0]     tone_gain [TABLE_DEPTH];
   bit                    entry_written [TABLE_DEPTH];

   pixel_result_type      expected_pixels [$];
   pixel_result_type      seen_pixel;
   pixel_result_type      want_pixel;
   int                    error_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   bit                    hold_request = 1'b0;
   int                    hold_left = 0;

   white_balance_tone_lut_pixel_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_blue_in       (req_blue_in),
      .req_green_in      (req_green_in),
      .req_red_in        (req_red_in),
      .req_table_address (req_table_address),
      .req_table_value   (req_table_value),
      .req_frame_last    (req_frame_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_frame_end     (rsp_frame_end),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [GAIN_W-1:0] scale_sample(input logic [PORT_W-1:0] s,
                                                       input logic [GAIN_W-1:0] gain);
      logic [PORT_W-1:0] smask;
      smask = cfg_wide ? 16'hFFFF : 16'h00FF;
      return GAIN_W'((36'(s & smask) * 36'(gain)) >> GAIN_SHIFT);
   endfunction

   function automatic logic [IDX_W-1:0] tone_index(input logic [GAIN_W-1:0] pb,
                                                    input logic [GAIN_W-1:0] pg,
                                                    input logic [GAIN_W-1:0] pr);
      logic [GAIN_W-1:0] top;
      logic [GAIN_W-1:0] top_limit;
      top_limit = cfg_wide ? 20'd65535 : 20'd255;
      top = pb;
      if (pg > top) top = pg;
      if (pr > top) top = pr;
      if (top > top_limit) top = top_limit;
      return top[IDX_W-1:0];
   endfunction

   function automatic logic [PORT_W-1:0] balance_channel(input logic [GAIN_W-1:0] prod,
                                                          input logic [IDX_W-1:0] idx,
                                                          input logic [TVAL_W-1:0] tg);
      longint full;
      longint capped;
      longint blend;
      longint value;
      full = cfg_wide ? 65536 : 256;
      capped = (longint'(prod) > full) ? full : longint'(prod);
      blend = (longint'(idx) <<< SAT_SHIFT) - longint'(cfg_saturation) * (longint'(idx) - capped);
      value = blend * longint'(tg);
      if (value <= 0) return '0;
      value = value >>> PROD_SHIFT;
      if (value > full - 1) value = full - 1;
      return value[PORT_W-1:0];
   endfunction

   function automatic pixel_result_type predict_balanced_pixel(input logic [PORT_W-1:0] b,
                                                               input logic [PORT_W-1:0] g,
                                                               input logic [PORT_W-1:0] r,
                                                               input logic last);
      logic [GAIN_W-1:0] pb;
      logic [GAIN_W-1:0] pg;
      logic [GAIN_W-1:0] pr;
      logic [IDX_W-1:0]  idx;
      pixel_result_type  res;
      pb = scale_sample(b, cfg_blue_gain);
      pg = scale_sample(g, cfg_green_gain);
      pr = scale_sample(r, cfg_red_gain);
      idx = tone_index(pb, pg, pr);
      res.blue = balance_channel(pb, idx, tone_gain[idx]);
      res.green = balance_channel(pg, idx, tone_gain[idx]);
      res.red = balance_channel(pr, idx, tone_gain[idx]);
      res.frame_end = last;
      return res;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_request(input op_type op,
                               input logic [PORT_W-1:0] b,
                               input logic [PORT_W-1:0] g,
                               input logic [PORT_W-1:0] r,
                               input logic [ADDR_W-1:0] addr,
                               input logic [TVAL_W-1:0] val,
                               input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_blue_in <= b;
      req_green_in <= g;
      req_red_in <= r;
      req_table_address <= addr;
      req_table_value <= val;
      req_frame_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // the request is in: update the table shadow or queue the pixel result
      if (op == OP_TABLE_WRITE) begin
         tone_gain[addr] = val;
         entry_written[addr] = 1'b1;
      end else begin
         expected_pixels.push_back(predict_balanced_pixel(b, g, r, last));
      end
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      // table writes still in flight give no response
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic drive_csr(input csr_index_type idx, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [GAIN_W-1:0] rg,
                                 input logic [GAIN_W-1:0] gg,
                                 input logic [GAIN_W-1:0] bg,
                                 input logic [SAT_W-1:0] sat,
                                 input logic wide);
      drive_csr(CSR_RED_GAIN, rg);
      drive_csr(CSR_GREEN_GAIN, gg);
      drive_csr(CSR_BLUE_GAIN, bg);
      drive_csr(CSR_SATURATION, CSR_W'(sat));
      drive_csr(CSR_WIDE_SAMPLES, CSR_W'(wide));
      csr_wr_en <= 1'b0;
      cfg_red_gain = rg;
      cfg_green_gain = gg;
      cfg_blue_gain = bg;
      cfg_saturation = sat;
      cfg_wide = wide;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1: begin
            send_idle_pct = 46;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 46;
         end
         3: begin
            send_idle_pct = 21;
            recv_stall_pct = 21;
         end
         default: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 20'd65536;
         3, 4: return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(40000, 100000));
      endcase
   endfunction

   function automatic logic [SAT_W-1:0] pick_saturation();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return 16'd16384;
         default: return SAT_W'($urandom);
      endcase
   endfunction

   function automatic logic [TVAL_W-1:0] pick_tone_gain();
      case ($urandom_range(3))
         0: return TVAL_W'($urandom_range(0, 24'h01FFFF));
         1: return TVAL_W'($urandom);
         default: return TVAL_W'($urandom_range(24'h008000, 24'h018000));
      endcase
   endfunction

   // Load the table entry the pixel will read if it is still empty, then send it.
   task automatic send_random_pixel();
      logic [PORT_W-1:0] b;
      logic [PORT_W-1:0] g;
      logic [PORT_W-1:0] r;
      logic [IDX_W-1:0]  idx;
      b = PORT_W'($urandom);
      g = PORT_W'($urandom);
      r = PORT_W'($urandom);
      idx = tone_index(scale_sample(b, cfg_blue_gain), scale_sample(g, cfg_green_gain),
                       scale_sample(r, cfg_red_gain));
      if (!entry_written[idx])
         send_request(OP_TABLE_WRITE, PORT_W'($urandom), PORT_W'($urandom), PORT_W'($urandom),
                      idx, pick_tone_gain(), 1'($urandom));
      send_request(OP_PIXEL, b, g, r, ADDR_W'($urandom), TVAL_W'($urandom),
                   $urandom_range(15) == 0);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_extremes();
      // reset settings: 8-bit samples, unity gains, unity saturation
      send_request(OP_TABLE_WRITE, '1, '1, '1, 16'd0, 24'd0, 1'b1);
      send_request(OP_TABLE_WRITE, '0, '0, '0, 16'd255, 24'hFFFFFF, 1'b0);
      send_request(OP_TABLE_WRITE, '0, '0, '0, 16'd128, 24'h010000, 1'b0);
      send_request(OP_PIXEL, 16'd0, 16'd0, 16'd0, '1, '1, 1'b0);
      send_request(OP_PIXEL, 16'd255, 16'd255, 16'd255, '0, '0, 1'b1);
      // upper sample bits are dropped in 8-bit mode
      send_request(OP_PIXEL, 16'hFF80, 16'h0080, 16'hAB80, '0, '0, 1'b0);
      send_request(OP_PIXEL, 16'd5, 16'd0, 16'd128, '0, '0, 1'b1);
      wait_until_idle();

      // heavy saturation pushes small channels below zero
      write_settings('1, '0, 20'd65536, '1, 1'b0);
      send_request(OP_TABLE_WRITE, '0, '0, '0, 16'd15, 24'h020000, 1'b0);
      send_request(OP_PIXEL, 16'd0, 16'd100, 16'd1, '0, '0, 1'b0);
      send_request(OP_PIXEL, 16'd200, 16'd255, 16'd255, '0, '0, 1'b1);
      wait_until_idle();

      // wide samples, largest gains, no saturation
      write_settings('1, '1, '1, '0, 1'b1);
      send_request(OP_TABLE_WRITE, '0, '0, '0, 16'hFFFF, 24'hFFFFFF, 1'b1);
      send_request(OP_TABLE_WRITE, '0, '0, '0, 16'd0, 24'h000001, 1'b0);
      send_request(OP_PIXEL, '1, '1, '1, '0, '0, 1'b1);
      send_request(OP_PIXEL, '0, '0, '0, '0, '0, 1'b0);
      wait_until_idle();
      write_settings(20'd65536, 20'd65536, 20'd65536, 16'd16384, 1'b0);
   endtask

   task automatic test_output_hold();
      set_idling(0);
      hold_request = 1'b1;
      repeat (60) send_random_pixel();
      wait_until_idle();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         wait_until_idle();
         write_settings(pick_gain(), pick_gain(), pick_gain(), pick_saturation(), 1'(ph % 2));
         set_idling(ph % 4);
         repeat (120) begin
            if ($urandom_range(9) == 0)
               send_request(OP_TABLE_WRITE, PORT_W'($urandom), PORT_W'($urandom),
                            PORT_W'($urandom), ADDR_W'($urandom), TVAL_W'($urandom),
                            1'($urandom));
            send_random_pixel();
         end
      end
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_pixel = '{blue: rsp_blue_out, green: rsp_green_out, red: rsp_red_out,
                        frame_end: rsp_frame_end};
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response: b=%0d g=%0d r=%0d end=%0d",
                        seen_pixel.blue, seen_pixel.green, seen_pixel.red,
                        seen_pixel.frame_end);
         end else begin
            want_pixel = expected_pixels.pop_front();
            if (seen_pixel.blue !== want_pixel.blue || seen_pixel.green !== want_pixel.green ||
                seen_pixel.red !== want_pixel.red ||
                seen_pixel.frame_end !== want_pixel.frame_end) begin
               error_count++;
               if (error_count <= 10)
                  $display("pixel mismatch: expected b=%0d g=%0d r=%0d end=%0d, got b=%0d g=%0d r=%0d end=%0d",
                           want_pixel.blue, want_pixel.green, want_pixel.red,
                           want_pixel.frame_end, seen_pixel.blue, seen_pixel.green,
                           seen_pixel.red, seen_pixel.frame_end);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_output_hold();
      test_random_phases();
      wait_until_idle();
      if (error_count == 0) begin
         $display("white_balance_tone_lut_pixel_top_test: clean");
      end else begin
         $display("white_balance_tone_lut_pixel_top_test: errors");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout: %0d responses still outstanding", expected_pixels.size());
      $display("white_balance_tone_lut_pixel_top_test: errors");
      $finish;
   end

endmodule
